>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

>>> rtl/mlbf_pkg.sv
`default_nettype none

package mlbf_pkg;

   localparam int unsigned ADDR_WIDTH = 48;

   typedef logic [ADDR_WIDTH-1:0] mac_addr_type;

   typedef enum logic [1:0] {
      VERDICT_FORWARD = 2'd0,
      VERDICT_DROP    = 2'd1,
      VERDICT_FLOOD   = 2'd2
   } verdict_type;

endpackage

`default_nettype wire

>>> rtl/mlbf_req_if.sv
`default_nettype none

interface mlbf_req_if;
   logic                  valid;
   logic                  ready;
   mlbf_pkg::mac_addr_type dst_address;
   mlbf_pkg::mac_addr_type src_address;
   logic                  arrival_port;

   modport source (output valid, output dst_address, output src_address,
                   output arrival_port, input ready);
   modport sink   (input valid, input dst_address, input src_address,
                   input arrival_port, output ready);
endinterface

`default_nettype wire

>>> rtl/mlbf_rsp_if.sv
`default_nettype none

interface mlbf_rsp_if;
   logic                  valid;
   logic                  ready;
   mlbf_pkg::verdict_type verdict;
   logic                  out_port;
   logic                  learn_failed;

   modport source (output valid, output verdict, output out_port,
                   output learn_failed, input ready);
   modport sink   (input valid, input verdict, input out_port,
                   input learn_failed, output ready);
endinterface

`default_nettype wire

>>> rtl/mac_learning_bridge_forward.sv
// Two-port learning bridge. Each header transaction on req_chan learns its
// source address (update of an existing entry, else the lowest free slot)
// and then looks up its destination: miss floods, hit on the arrival port
// drops, hit on the other port forwards. Headers with both addresses zero
// produce no response. The table lives in flip-flops and is compared against
// both addresses in parallel, so one header is taken every cycle while the
// response register is not stalled; each header passes the input register,
// then the compare-and-update stage that loads the response register. The
// table is empty right after reset, with no clearing pass. learn_failed flags
// a new source dropped because every entry was in use.
`default_nettype none

`include "assert_macros.svh"

module mac_learning_bridge_forward #(
   parameter int unsigned TABLE_ENTRIES = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mlbf_req_if.sink   req_chan,
   mlbf_rsp_if.source rsp_chan
);

   // input register
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   mlbf_pkg::mac_addr_type s1_dst_ff;
   mlbf_pkg::mac_addr_type s1_src_ff;
   logic                   s1_port_ff;

   // table
   logic [TABLE_ENTRIES-1:0] entry_valid_ff;
   logic [TABLE_ENTRIES-1:0] entry_valid_in;
   mlbf_pkg::mac_addr_type   entry_address_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] entry_port_ff;

   // response register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   mlbf_pkg::verdict_type rsp_verdict_ff;
   mlbf_pkg::verdict_type rsp_verdict_in;
   logic                  rsp_out_port_ff;
   logic                  rsp_out_port_in;
   logic                  rsp_learn_failed_ff;
   logic                  rsp_learn_failed_in;

   logic                     s1_empty;
   logic                     out_free;
   logic                     s1_fire;
   logic                     learn_en;
   logic [TABLE_ENTRIES-1:0] src_hit;
   logic [TABLE_ENTRIES-1:0] dst_hit;
   logic [TABLE_ENTRIES-1:0] free_onehot;
   logic [TABLE_ENTRIES-1:0] alloc;
   logic [TABLE_ENTRIES-1:0] port_wr;
   logic                     src_known;
   logic                     table_full;
   logic                     learn_ok;
   logic                     dst_known;
   logic                     dst_port;

   // ---------------- handshake ----------------
   assign s1_empty = (s1_dst_ff == '0) && (s1_src_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   // empty headers retire without needing the response register
   assign s1_fire  = s1_valid_ff && (s1_empty || out_free);
   assign learn_en = s1_fire && !s1_empty;

   assign req_chan.ready = !s1_valid_ff || s1_fire;

   assign s1_valid_in = req_chan.valid ? 1'b1 : (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_dst_ff  <= req_chan.dst_address;
         s1_src_ff  <= req_chan.src_address;
         s1_port_ff <= req_chan.arrival_port;
      end
   end

   // ---------------- associative compare ----------------
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         src_hit[i] = entry_valid_ff[i] && (entry_address_ff[i] == s1_src_ff);
         dst_hit[i] = entry_valid_ff[i] && (entry_address_ff[i] == s1_dst_ff);
      end
   end

   // lowest clear bit of the valid vector
   assign free_onehot = ~entry_valid_ff & (entry_valid_ff + TABLE_ENTRIES'(1));
   assign src_known   = |src_hit;
   assign table_full  = &entry_valid_ff;
   assign learn_ok    = src_known || !table_full;
   assign alloc       = src_known ? '0 : free_onehot;
   assign port_wr     = src_hit | alloc;

   assign dst_known = |dst_hit;
   assign dst_port  = |(dst_hit & entry_port_ff);

   // ---------------- table update ----------------
   assign entry_valid_in = entry_valid_ff | (learn_en ? alloc : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (learn_en && alloc[i]) begin
            entry_address_ff[i] <= s1_src_ff;
         end
         if (learn_en && port_wr[i]) begin
            entry_port_ff[i] <= s1_port_ff;
         end
      end
   end

   // ---------------- verdict ----------------
   always_comb begin
      rsp_out_port_in     = 1'b0;
      rsp_learn_failed_in = !learn_ok;
      if (s1_dst_ff == s1_src_ff) begin
         // destination is the source just learned, or not learned at all
         rsp_verdict_in = learn_ok ? mlbf_pkg::VERDICT_DROP : mlbf_pkg::VERDICT_FLOOD;
      end else if (!dst_known) begin
         rsp_verdict_in = mlbf_pkg::VERDICT_FLOOD;
      end else if (dst_port == s1_port_ff) begin
         rsp_verdict_in = mlbf_pkg::VERDICT_DROP;
      end else begin
         rsp_verdict_in  = mlbf_pkg::VERDICT_FORWARD;
         rsp_out_port_in = dst_port;
      end
   end

   assign rsp_valid_in = learn_en ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (learn_en) begin
         rsp_verdict_ff      <= rsp_verdict_in;
         rsp_out_port_ff     <= rsp_out_port_in;
         rsp_learn_failed_ff <= rsp_learn_failed_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.verdict      = rsp_verdict_ff;
   assign rsp_chan.out_port     = rsp_out_port_ff;
   assign rsp_chan.learn_failed = rsp_learn_failed_ff;

   // ---------------- assertions ----------------
   `ASSERT_PROP(a_src_unique, clock, reset, $onehot0(src_hit))
   `ASSERT_PROP(a_fail_only_when_full, clock, reset,
                (learn_en && rsp_learn_failed_in) |-> table_full)
   `ASSERT_NEVER(a_forward_to_arrival, clock, reset,
                 learn_en && (rsp_verdict_in == mlbf_pkg::VERDICT_FORWARD)
                 && (rsp_out_port_in == s1_port_ff))
   `ASSERT_PROP(a_valid_never_clears, clock, reset,
                1'b1 |=> (($past(entry_valid_ff) & ~entry_valid_ff) == '0))
   `ASSERT_PROP(a_one_alloc, clock, reset, $onehot0(alloc))

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SIZE = 64;
   localparam int POOL_SIZE = 128;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct packed {
      mlbf_pkg::mac_addr_type dst;
      mlbf_pkg::mac_addr_type src;
      logic                   port;
      logic                   drain;
   } frame_hdr_type;

   typedef struct packed {
      mlbf_pkg::verdict_type verdict;
      logic                  out_port;
      logic                  learn_failed;
   } fwd_decision_type;

   logic clock;
   logic reset;

   mlbf_req_if req_if ();
   mlbf_rsp_if rsp_if ();

   mac_learning_bridge_forward #(
      .TABLE_ENTRIES(TABLE_SIZE)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   frame_hdr_type    pending_frames[$];
   fwd_decision_type expected_decisions[$];

   // predictor copy of the station table
   bit                     station_valid[TABLE_SIZE];
   mlbf_pkg::mac_addr_type station_addr[TABLE_SIZE];
   logic                   station_port[TABLE_SIZE];

   mlbf_pkg::mac_addr_type addr_pool[POOL_SIZE];

   int unsigned mismatches;
   int unsigned send_gap;
   int unsigned stall_left;
   int unsigned steady_left;
   bit          steady;
   int unsigned idle_cycles;

   function automatic mlbf_pkg::mac_addr_type rand_mac();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[47:0];
   endfunction

   // idle length for either side; zero throughout steady stretches
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (steady || r < 65) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 6);
   endfunction

   function automatic int find_station(input mlbf_pkg::mac_addr_type a);
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (station_valid[i] && station_addr[i] == a) return i;
      end
      return -1;
   endfunction

   // learns the source, then decides on the destination; 0 when no result
   function automatic bit bridge_decide(input frame_hdr_type f, output fwd_decision_type d);
      int slot;
      d.verdict = mlbf_pkg::VERDICT_FLOOD;
      d.out_port = 1'b0;
      d.learn_failed = 1'b0;
      if (f.dst == '0 && f.src == '0) return 1'b0;
      slot = find_station(f.src);
      if (slot < 0) begin
         for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if (!station_valid[i]) slot = i;
         end
         if (slot >= 0) begin
            station_valid[slot] = 1'b1;
            station_addr[slot] = f.src;
         end
      end
      if (slot >= 0) station_port[slot] = f.port;
      else d.learn_failed = 1'b1;
      slot = find_station(f.dst);
      if (slot >= 0) begin
         if (station_port[slot] == f.port) begin
            d.verdict = mlbf_pkg::VERDICT_DROP;
         end else begin
            d.verdict = mlbf_pkg::VERDICT_FORWARD;
            d.out_port = station_port[slot];
         end
      end
      return 1'b1;
   endfunction

   task automatic add_frame(input mlbf_pkg::mac_addr_type dst,
                            input mlbf_pkg::mac_addr_type src,
                            input logic port, input logic drain);
      frame_hdr_type f;
      f.dst = dst;
      f.src = src;
      f.port = port;
      f.drain = drain;
      pending_frames.push_back(f);
   endtask

   // count excludes empty frames, which the bridge ignores
   task automatic queue_random_frames(input int unsigned count, input int unsigned span,
                                      input bit wild_src);
      int unsigned made;
      int unsigned r;
      mlbf_pkg::mac_addr_type s;
      mlbf_pkg::mac_addr_type d;
      made = 0;
      while (made < count) begin
         r = $urandom_range(99);
         s = addr_pool[$urandom_range(span - 1)];
         d = addr_pool[$urandom_range(span - 1)];
         if (r < 3) begin
            s = '0;
            d = '0;
         end else begin
            made++;
            if (r < 6) s = '0;
            else if (r < 8) d = '0;
            else if (r < 18) d = s;
            else if (r < 28) d = rand_mac();
            else if (r < 34 && wild_src) s = rand_mac();
         end
         add_frame(d, s, 1'($urandom_range(1)), $urandom_range(99) == 0);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      mlbf_pkg::mac_addr_type m;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.dst_address = '0;
      req_if.src_address = '0;
      req_if.arrival_port = 1'b0;
      rsp_if.ready = 1'b0;
      mismatches = 0;

      addr_pool[0] = '1;
      addr_pool[1] = 48'h0000_0000_0001;
      addr_pool[2] = 48'h8000_0000_0000;
      addr_pool[3] = 48'haaaa_aaaa_aaaa;
      addr_pool[4] = 48'h5555_5555_5555;
      for (int i = 5; i < POOL_SIZE; i++) addr_pool[i] = rand_mac();

      // empty frames, zero as a learned address, all-ones address
      add_frame('0, '0, 1'b0, 1'b0);
      add_frame(addr_pool[0], '0, 1'b0, 1'b0);
      add_frame('0, addr_pool[0], 1'b1, 1'b0);
      add_frame(addr_pool[0], '0, 1'b0, 1'b0);
      add_frame(addr_pool[0], addr_pool[1], 1'b1, 1'b0);
      // destination equal to source drops
      add_frame(addr_pool[2], addr_pool[2], 1'b0, 1'b0);
      // stations moving between ports
      add_frame(addr_pool[1], addr_pool[2], 1'b1, 1'b0);
      add_frame(addr_pool[2], addr_pool[1], 1'b0, 1'b0);
      add_frame('0, '0, 1'b1, 1'b1);
      add_frame(addr_pool[3], addr_pool[4], 1'b1, 1'b0);
      add_frame(addr_pool[4], addr_pool[3], 1'b0, 1'b0);
      add_frame(addr_pool[3], addr_pool[4], 1'b0, 1'b0);
      add_frame(addr_pool[4], addr_pool[3], 1'b0, 1'b1);
      add_frame(addr_pool[1], addr_pool[0], 1'b0, 1'b0);

      // fewer distinct sources than entries, so learning never fails here
      queue_random_frames(850, 40, 1'b0);
      // enough sources to fill the table and keep it full
      queue_random_frames(500, POOL_SIZE, 1'b1);

      m = rand_mac();
      add_frame(m, m, 1'b0, 1'b1);
      add_frame(addr_pool[0], addr_pool[0], 1'b1, 1'b0);
      add_frame(addr_pool[3], rand_mac(), 1'b1, 1'b0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_frames.size() != 0 || req_if.valid || expected_decisions.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_decisions.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  expected_decisions.size());
      end
      if (mismatches == 0 && expected_decisions.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (steady_left == 0) begin
         steady <= !steady;
         steady_left <= $urandom_range(400, 100);
      end else begin
         steady_left <= steady_left - 1;
      end
   end

   always @(posedge clock) begin : frame_driver
      frame_hdr_type nxt;
      frame_hdr_type taken;
      fwd_decision_type d;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            taken.dst = req_if.dst_address;
            taken.src = req_if.src_address;
            taken.port = req_if.arrival_port;
            taken.drain = 1'b0;
            if (bridge_decide(taken, d)) expected_decisions.push_back(d);
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_if.valid <= 1'b0;
            end else if (pending_frames.size() != 0 &&
                         !(pending_frames[0].drain && expected_decisions.size() != 0)) begin
               nxt = pending_frames.pop_front();
               req_if.valid <= 1'b1;
               req_if.dst_address <= nxt.dst;
               req_if.src_address <= nxt.src;
               req_if.arrival_port <= nxt.port;
               send_gap <= pick_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : decision_monitor
      fwd_decision_type want;
      int unsigned s;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_decisions.size() == 0) begin
               $display("%0t: unexpected result verdict=%0d out_port=%0d learn_failed=%0d",
                        $time, rsp_if.verdict, rsp_if.out_port, rsp_if.learn_failed);
               mismatches++;
            end else begin
               want = expected_decisions.pop_front();
               if (rsp_if.verdict !== want.verdict) begin
                  $display("%0t: verdict expected %0d actual %0d", $time,
                           want.verdict, rsp_if.verdict);
                  mismatches++;
               end
               if (rsp_if.out_port !== want.out_port) begin
                  $display("%0t: out_port expected %0d actual %0d", $time,
                           want.out_port, rsp_if.out_port);
                  mismatches++;
               end
               if (rsp_if.learn_failed !== want.learn_failed) begin
                  $display("%0t: learn_failed expected %0d actual %0d", $time,
                           want.learn_failed, rsp_if.learn_failed);
                  mismatches++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            s = pick_gap();
            rsp_if.ready <= (s == 0);
            stall_left <= (s == 0) ? 0 : s - 1;
         end
      end
   end

   // ends a hung run: no transaction on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
